/* rtl/ltt_pkg.sv */
// Shared types and constants for the LRU tag table.
// Used by ltt_ctrl, ltt_dp and lru_tag_table.
package ltt_pkg;

    localparam int OP_W   = 3;
    localparam int KEY_W  = 32;
    localparam int SLOT_W = 5;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [KEY_W-1:0] key_t;

    localparam op_t OP_REQUEST = 3'd0;
    localparam op_t OP_GET     = 3'd1;
    localparam op_t OP_TOUCH   = 3'd2;
    localparam op_t OP_STORE   = 3'd3;
    localparam op_t OP_CLEAR   = 3'd4;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ltt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ltt_stat_t;

endpackage

/* rtl/lru_tag_table.sv */
// LRU tag table top level: fully associative key table with least-recent eviction.
// Depends on ltt_pkg, ltt_ctrl and ltt_dp.
//
// Usage:
//   Input channel s_valid/s_ready carries one word: s_op (request, get, touch,
//   store, clear) and s_key_id. Key zero makes ops other than clear a no-op.
//   Result channel m_valid/m_ready returns exactly one word per input word:
//   found, is_loaded, slot, fetch_needed, evicted, evicted_key.
// Scan:
//   After a word is taken the entries below the fill count are scanned, one
//   memory read per cycle with the compare in the following cycle; clear and
//   no-op words skip the scan. Key match and oldest stamp come out of the same
//   pass; one word is in work at a time.
// Reset:
//   aresetn clears the fill count and use clock; s_ready rises in the cycle after
//   reset is released. Entry memories are not cleared.
// Back-pressure:
//   A waiting result is held on m_*; the next word is still taken and scanned,
//   and its result is written once the previous one has been taken.
module lru_tag_table #(
    parameter int ENTRIES    = 24,
    parameter int STAMP_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ltt_pkg::op_t  s_op,
    input  ltt_pkg::key_t s_key_id,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_found,
    output logic          m_is_loaded,
    output logic [4:0]    m_slot,
    output logic          m_fetch_needed,
    output logic          m_evicted,
    output ltt_pkg::key_t m_evicted_key
);
    import ltt_pkg::*;

    ltt_cmd_t  cmd;
    ltt_stat_t stat;

    ltt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ltt_dp #(
        .ENTRIES    (ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_op           (s_op),
        .s_key_id       (s_key_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_is_loaded    (m_is_loaded),
        .m_slot         (m_slot),
        .m_fetch_needed (m_fetch_needed),
        .m_evicted      (m_evicted),
        .m_evicted_key  (m_evicted_key)
    );

endmodule

/* rtl/ltt_ctrl.sv */
// Sequencing state machine for the LRU tag table.
// Depends on ltt_pkg; drives the command struct of ltt_dp.
module ltt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output ltt_pkg::ltt_cmd_t  cmd,
    input  ltt_pkg::ltt_stat_t stat
);
    import ltt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

/* rtl/ltt_dp.sv */
// Datapath of the LRU tag table: entry memories, scan unit, use clock, result word.
// Depends on ltt_pkg; controlled by ltt_ctrl.
module ltt_dp #(
    parameter int ENTRIES    = 24,
    parameter int STAMP_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ltt_pkg::ltt_cmd_t   cmd,
    output ltt_pkg::ltt_stat_t  stat,
    input  ltt_pkg::op_t        s_op,
    input  ltt_pkg::key_t       s_key_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic                m_is_loaded,
    output logic [4:0]          m_slot,
    output logic                m_fetch_needed,
    output logic                m_evicted,
    output ltt_pkg::key_t       m_evicted_key
);
    import ltt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;

    key_t   key_mem   [ENTRIES];
    logic   ready_mem [ENTRIES];
    stamp_t stamp_mem [ENTRIES];

    op_t    op_reg;
    key_t   key_reg;
    cnt_t   fill_count_reg;
    stamp_t use_clock_reg;

    cnt_t   issue_idx_reg;
    logic   cmp_valid_reg;
    idx_t   cmp_idx_reg;
    key_t   key_rd_reg;
    logic   ready_rd_reg;
    stamp_t stamp_rd_reg;

    logic   hit_reg;
    idx_t   hit_idx_reg;
    logic   hit_ready_reg;
    stamp_t min_stamp_reg;
    idx_t   lru_idx_reg;
    key_t   lru_key_reg;

    logic   m_valid_reg;
    logic   m_found_reg;
    logic   m_is_loaded_reg;
    logic [4:0] m_slot_reg;
    logic   m_fetch_needed_reg;
    logic   m_evicted_reg;
    key_t   m_evicted_key_reg;

    logic   valid_op, req_or_store, alloc_op, has_free, do_refresh, issue_en;
    logic   key_we, ready_we, stamp_we;
    idx_t   rd_addr, alloc_idx, wr_idx;
    stamp_t use_next;
    logic [EXT_W-1:0] slot_ext;

    // decode of the held item
    assign valid_op     = (op_reg <= OP_STORE) && (key_reg != '0);
    assign req_or_store = (op_reg == OP_REQUEST) || (op_reg == OP_STORE);
    assign alloc_op     = valid_op && req_or_store && !hit_reg;
    assign has_free     = fill_count_reg < CNT_W'(ENTRIES);
    assign alloc_idx    = has_free ? fill_count_reg[IDX_W-1:0] : lru_idx_reg;
    assign wr_idx       = hit_reg ? hit_idx_reg : alloc_idx;
    assign do_refresh   = valid_op
                          && (req_or_store || (hit_reg && ((op_reg == OP_TOUCH) || hit_ready_reg)));
    assign use_next     = use_clock_reg + 1'b1;
    assign slot_ext     = EXT_W'(wr_idx);

    assign key_we   = cmd.commit && alloc_op;
    assign ready_we = cmd.commit && valid_op && req_or_store
                      && ((op_reg == OP_STORE) || !hit_reg);
    assign stamp_we = cmd.commit && do_refresh;

    assign issue_en = cmd.scan && valid_op && (issue_idx_reg < fill_count_reg);
    assign rd_addr  = issue_en ? issue_idx_reg[IDX_W-1:0] : '0;

    assign stat.scan_done = !valid_op
                            || ((issue_idx_reg == fill_count_reg) && !cmp_valid_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // entry memories
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_idx] <= key_reg;
        end
        if (ready_we) begin
            ready_mem[wr_idx] <= (op_reg == OP_STORE);
        end
        if (stamp_we) begin
            stamp_mem[wr_idx] <= use_next;
        end
        key_rd_reg   <= key_mem[rd_addr];
        ready_rd_reg <= ready_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
    end

    // scan: one read issued per cycle, compared in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else if (cmd.start) begin
            op_reg        <= s_op;
            key_reg       <= s_key_id;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else if (cmd.scan) begin
            cmp_valid_reg <= issue_en;
            if (issue_en) begin
                cmp_idx_reg   <= issue_idx_reg[IDX_W-1:0];
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (cmp_valid_reg) begin
                if (!hit_reg && (key_rd_reg == key_reg)) begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= cmp_idx_reg;
                    hit_ready_reg <= ready_rd_reg;
                end
                if ((cmp_idx_reg == '0) || (stamp_rd_reg < min_stamp_reg)) begin
                    min_stamp_reg <= stamp_rd_reg;
                    lru_idx_reg   <= cmp_idx_reg;
                    lru_key_reg   <= key_rd_reg;
                end
            end
        end
    end

    // table state and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            use_clock_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (op_reg == OP_CLEAR) begin
                    fill_count_reg <= '0;
                end else if (alloc_op && has_free) begin
                    fill_count_reg <= fill_count_reg + 1'b1;
                end
                if (do_refresh) begin
                    use_clock_reg <= use_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_found_reg        <= valid_op && hit_reg;
            m_is_loaded_reg    <= valid_op
                                  && ((op_reg == OP_STORE) || (hit_reg && hit_ready_reg));
            m_slot_reg         <= (valid_op && (req_or_store || hit_reg)) ? slot_ext[4:0] : '0;
            m_fetch_needed_reg <= alloc_op && (op_reg == OP_REQUEST);
            m_evicted_reg      <= alloc_op && !has_free;
            m_evicted_key_reg  <= (alloc_op && !has_free) ? lru_key_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_is_loaded    = m_is_loaded_reg;
    assign m_slot         = m_slot_reg;
    assign m_fetch_needed = m_fetch_needed_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_evicted_key  = m_evicted_key_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        key_we && !has_free |-> fill_count_reg == CNT_W'(ENTRIES))
        else $error("eviction while table not full");

    a_fetch_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_fetch_needed_reg |-> !m_found_reg && !m_is_loaded_reg)
        else $error("fetch flagged on a hit or loaded entry");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("result word lost after commit");

endmodule
